>>> src/rvie_pkg.sv
// ----------------------------------------------------------------------------
// rvie_pkg
// Shared types and constants of the register VM integer execute unit.
// ----------------------------------------------------------------------------
package rvie_pkg;

  localparam int FULL_W = 64;
  localparam int PTR_W  = 32;
  localparam int IDX_W  = 16;
  localparam int OP_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_NOP   = 5'd0,
    OP_ADD   = 5'd1,
    OP_SUB   = 5'd2,
    OP_MUL   = 5'd3,
    OP_DIV   = 5'd4,
    OP_MOD   = 5'd5,
    OP_EQ    = 5'd6,
    OP_GT    = 5'd7,
    OP_LT    = 5'd8,
    OP_NE    = 5'd9,
    OP_GE    = 5'd10,
    OP_LE    = 5'd11,
    OP_AND   = 5'd12,
    OP_OR    = 5'd13,
    OP_XOR   = 5'd14,
    OP_NOT   = 5'd15,
    OP_NEG   = 5'd16,
    OP_LSH   = 5'd17,
    OP_RSH   = 5'd18,
    OP_LDI   = 5'd19,
    OP_COPY  = 5'd20,
    OP_ARGC  = 5'd21,
    OP_JMP   = 5'd22,
    OP_JCOND = 5'd23,
    OP_HOST  = 5'd24,
    OP_RET   = 5'd25
  } op_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [1:0] ERR_INDEX    = 2'd2;

  localparam logic CFG_ARGC  = 1'b0;
  localparam logic CFG_START = 1'b1;

  typedef enum logic [1:0] {
    RD_DEST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef struct packed {
    logic    clr_we;
    logic    load;
    rd_sel_t rd_sel;
    logic    cap_d;
    logic    cap_a;
    logic    cap_b;
    logic    start;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_unit;
    logic unit_busy;
  } sts_t;

endpackage

>>> src/rvie_ram.sv
// ----------------------------------------------------------------------------
// rvie_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rvie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rvie_ctrl.sv
// ----------------------------------------------------------------------------
// rvie_ctrl
// Sequencer: clearing pass, operand reads, unit wait and result handoff.
// ----------------------------------------------------------------------------
module rvie_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output rvie_pkg::cmd_t cmd,
  input  rvie_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDD,
    S_RDL,
    S_RDR,
    S_LATB,
    S_START,
    S_UNIT,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = rvie_pkg::RD_DEST;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RDD;
        end
      end
      S_RDD: begin
        cmd.rd_sel = rvie_pkg::RD_DEST;
        state_nxt  = S_RDL;
      end
      S_RDL: begin
        cmd.rd_sel = rvie_pkg::RD_LEFT;
        cmd.cap_d  = 1'b1;
        state_nxt  = S_RDR;
      end
      S_RDR: begin
        cmd.rd_sel = rvie_pkg::RD_RIGHT;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_LATB;
      end
      S_LATB: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.start = sts.need_unit;
        state_nxt = sts.need_unit ? S_UNIT : S_DONE;
      end
      S_UNIT: begin
        if (!sts.unit_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> src/rvie_dp.sv
// ----------------------------------------------------------------------------
// rvie_dp
// Datapath: operand store, instruction pointer, ALU, shared multiplier and
// radix-2 divider, and the result register.
// ----------------------------------------------------------------------------
module rvie_dp #(
  parameter int BANK_DEPTH  = 256,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rvie_pkg::cmd_t               cmd,
  output rvie_pkg::sts_t               sts,
  input  logic [rvie_pkg::OP_W-1:0]    operation,
  input  logic [1:0]                   dest_bank,
  input  logic [rvie_pkg::IDX_W-1:0]   dest_index,
  input  logic [1:0]                   left_bank,
  input  logic [rvie_pkg::IDX_W-1:0]   left_field,
  input  logic [1:0]                   right_bank,
  input  logic [rvie_pkg::IDX_W-1:0]   right_field,
  input  logic [rvie_pkg::FULL_W-1:0]  host_value,
  input  logic [7:0]                   argument_count,
  input  logic [rvie_pkg::PTR_W-1:0]   start_pointer,
  input  logic                         ip_load,
  output logic [rvie_pkg::FULL_W-1:0]  result_value,
  output logic                         wrote,
  output logic [rvie_pkg::PTR_W-1:0]   next_pointer,
  output logic                         branch_taken,
  output logic                         returned,
  output logic [1:0]                   error_code
);

  localparam int DEPTH = 4 * BANK_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = rvie_pkg::FULL_W;

  function automatic logic [AW-1:0] addr_of(input logic [1:0] bank,
                                            input logic [rvie_pkg::IDX_W-1:0] idx);
    logic [AW-1:0] base;
    unique case (bank)
      2'd0:    base = '0;
      2'd1:    base = AW'(BANK_DEPTH);
      2'd2:    base = AW'(2 * BANK_DEPTH);
      default: base = AW'(3 * BANK_DEPTH);
    endcase
    return base + AW'(idx);
  endfunction

  function automatic logic idx_bad(input logic [rvie_pkg::IDX_W-1:0] idx);
    return {1'b0, idx} >= (rvie_pkg::IDX_W + 1)'(BANK_DEPTH);
  endfunction

  function automatic logic [FW-1:0] wrapv(input logic [FW-1:0] v);
    return FW'($signed(v[VALUE_WIDTH-1:0]));
  endfunction

  logic [rvie_pkg::OP_W-1:0]  op_r;
  logic [1:0]                 db_r, lb_r, rb_r;
  logic [rvie_pkg::IDX_W-1:0] di_r, lf_r, rf_r;
  logic [FW-1:0]              hv_r;
  logic [FW-1:0]              d_r, a_r, b_r;
  logic [rvie_pkg::PTR_W-1:0] ip_r;
  logic [AW-1:0]              clr_cnt_r;
  logic                       busy_r;
  logic                       mode_div_r;
  logic [5:0]                 cnt_r;
  logic [FW-1:0]              p_r, acc_r, dq_r, rem_r;

  logic [AW-1:0]              da, la, ra, raddr, waddr;
  logic [VALUE_WIDTH-1:0]     rdata, wdata;
  logic                       we;
  logic [FW-1:0]              rd_ext;
  logic                       use_d, use_l, use_r, err_idx, err_zero, is_divmod;
  logic [FW-1:0]              mb, q_fix, r_fix, calc, res_w;
  logic                       wr_w, br_w, ret_w;
  logic [1:0]                 err_w;
  logic [rvie_pkg::PTR_W-1:0] imm32, next_w;
  logic [FW:0]                rem_sh;
  logic                       ge;
  logic [31:0]                mx, my;

  assign da = addr_of(db_r, di_r);
  assign la = addr_of(lb_r, lf_r);
  assign ra = addr_of(rb_r, rf_r);

  always_comb begin
    unique case (cmd.rd_sel)
      rvie_pkg::RD_LEFT:  raddr = la;
      rvie_pkg::RD_RIGHT: raddr = ra;
      default:            raddr = da;
    endcase
  end

  assign we    = cmd.clr_we || (cmd.commit && wr_w);
  assign waddr = cmd.clr_we ? clr_cnt_r : da;
  assign wdata = cmd.clr_we ? '0 : res_w[VALUE_WIDTH-1:0];

  rvie_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ext = FW'($signed(rdata));

  always_comb begin
    use_d = ((op_r >= rvie_pkg::OP_ADD) && (op_r <= rvie_pkg::OP_ARGC)) ||
            (op_r == rvie_pkg::OP_JCOND) || (op_r == rvie_pkg::OP_HOST) ||
            (op_r == rvie_pkg::OP_RET);
    use_l = ((op_r >= rvie_pkg::OP_ADD) && (op_r <= rvie_pkg::OP_RSH)) ||
            (op_r == rvie_pkg::OP_COPY);
    use_r = ((op_r >= rvie_pkg::OP_ADD) && (op_r <= rvie_pkg::OP_XOR)) ||
            (op_r == rvie_pkg::OP_LSH) || (op_r == rvie_pkg::OP_RSH);
  end

  assign err_idx   = (use_d && idx_bad(di_r)) || (use_l && idx_bad(lf_r)) ||
                     (use_r && idx_bad(rf_r));
  assign is_divmod = (op_r == rvie_pkg::OP_DIV) || (op_r == rvie_pkg::OP_MOD);
  assign err_zero  = !err_idx && is_divmod && (b_r == '0);

  assign sts.need_unit = !err_idx && ((op_r == rvie_pkg::OP_MUL) || (is_divmod && !err_zero));
  assign sts.unit_busy = busy_r;
  assign sts.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));

  assign mb    = b_r[FW-1] ? -b_r : b_r;
  assign q_fix = (a_r[FW-1] ^ b_r[FW-1]) ? -dq_r : dq_r;
  assign r_fix = a_r[FW-1] ? -rem_r : rem_r;
  assign imm32 = {lf_r, rf_r};

  always_comb begin
    calc = '0;
    wr_w = 1'b1;
    unique case (op_r)
      rvie_pkg::OP_ADD:   calc = a_r + b_r;
      rvie_pkg::OP_SUB:   calc = a_r - b_r;
      rvie_pkg::OP_MUL:   calc = acc_r;
      rvie_pkg::OP_DIV:   calc = q_fix;
      rvie_pkg::OP_MOD:   calc = r_fix;
      rvie_pkg::OP_EQ:    calc = FW'(a_r == b_r);
      rvie_pkg::OP_GT:    calc = FW'($signed(a_r) > $signed(b_r));
      rvie_pkg::OP_LT:    calc = FW'($signed(a_r) < $signed(b_r));
      rvie_pkg::OP_NE:    calc = FW'(a_r != b_r);
      rvie_pkg::OP_GE:    calc = FW'($signed(a_r) >= $signed(b_r));
      rvie_pkg::OP_LE:    calc = FW'($signed(a_r) <= $signed(b_r));
      rvie_pkg::OP_AND:   calc = a_r & b_r;
      rvie_pkg::OP_OR:    calc = a_r | b_r;
      rvie_pkg::OP_XOR:   calc = a_r ^ b_r;
      rvie_pkg::OP_NOT:   calc = ~a_r;
      rvie_pkg::OP_NEG:   calc = -a_r;
      rvie_pkg::OP_LSH:   calc = a_r << b_r[5:0];
      rvie_pkg::OP_RSH:   calc = $signed(a_r) >>> b_r[5:0];
      rvie_pkg::OP_LDI:   calc = FW'(imm32);
      rvie_pkg::OP_COPY:  calc = a_r;
      rvie_pkg::OP_ARGC:  calc = FW'(argument_count);
      rvie_pkg::OP_HOST:  calc = hv_r;
      default:            wr_w = 1'b0;
    endcase
    if (err_idx || err_zero) begin
      wr_w = 1'b0;
    end
  end

  always_comb begin
    ret_w  = (op_r == rvie_pkg::OP_RET);
    err_w  = err_idx ? rvie_pkg::ERR_INDEX : (err_zero ? rvie_pkg::ERR_ZERO_DIV
                                                        : rvie_pkg::ERR_NONE);
    br_w   = !err_idx && ((op_r == rvie_pkg::OP_JMP) ||
                          ((op_r == rvie_pkg::OP_JCOND) && (d_r != '0)));
    next_w = ip_r + 1'b1;
    res_w  = '0;
    if (wr_w) begin
      res_w = wrapv(calc);
    end
    if (br_w) begin
      next_w = ip_r + 1'b1 + imm32;
    end else if ((op_r == rvie_pkg::OP_HOST) && !err_idx) begin
      next_w = ip_r;
    end
    if (ret_w) begin
      res_w  = err_idx ? '0 : d_r;
      next_w = start_pointer;
    end
  end

  assign rem_sh = {rem_r, dq_r[FW-1]};
  assign ge     = rem_sh >= {1'b0, mb};
  assign mx     = (cnt_r == 6'd1) ? a_r[63:32] : a_r[31:0];
  assign my     = (cnt_r == 6'd2) ? b_r[63:32] : b_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r      <= '0;
      clr_cnt_r <= '0;
      busy_r    <= 1'b0;
    end else begin
      if (cmd.clr_we) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        ip_r <= next_w;
      end else if (ip_load) begin
        ip_r <= start_pointer;
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (mode_div_r ? (cnt_r == 6'd63) : (cnt_r == 6'd3))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= operation;
      db_r <= dest_bank;
      di_r <= dest_index;
      lb_r <= left_bank;
      lf_r <= left_field;
      rb_r <= right_bank;
      rf_r <= right_field;
      hv_r <= host_value;
    end
    if (cmd.cap_d) begin
      d_r <= rd_ext;
    end
    if (cmd.cap_a) begin
      a_r <= rd_ext;
    end
    if (cmd.cap_b) begin
      b_r <= rd_ext;
    end
    if (cmd.start) begin
      cnt_r      <= '0;
      mode_div_r <= (op_r != rvie_pkg::OP_MUL);
      rem_r      <= '0;
      dq_r       <= a_r[FW-1] ? -a_r : a_r;
      acc_r      <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (mode_div_r) begin
        rem_r <= ge ? rem_sh[FW-1:0] - mb : rem_sh[FW-1:0];
        dq_r  <= {dq_r[FW-2:0], ge};
      end else begin
        p_r <= mx * my;
        if (cnt_r == 6'd1) begin
          acc_r <= p_r;
        end else if (cnt_r != 6'd0) begin
          acc_r <= acc_r + {p_r[31:0], 32'd0};
        end
      end
    end
    if (cmd.commit) begin
      result_value <= res_w;
      wrote        <= wr_w;
      next_pointer <= next_w;
      branch_taken <= br_w;
      returned     <= ret_w;
      error_code   <= err_w;
    end
  end

endmodule

>>> src/register_vm_integer_execute_top.sv
// ----------------------------------------------------------------------------
// register_vm_integer_execute_top
// Executes one three-operand integer instruction of a register bytecode
// machine per request and returns its result, pointer and error status.
//
// The in_ channel takes one instruction per request; the out_ channel returns
// one result per instruction, in order. The cfg_ port sets the argument count
// and the start pointer; writing the start pointer also loads the instruction
// pointer. Writes are expected only while the unit is idle.
// After reset the operand store is cleared, one word per cycle, through all
// 4*BANK_DEPTH words; in_tready stays low while it is being cleared.
// One instruction is worked on at a time: three operand store reads through
// the single RAM read port, then evaluation and write-back. Multiply first
// sums its 32x32 partial products, and divide or modulo first runs the
// bit-serial divider. The next request is taken as soon as a result
// sits in the output register; if the receiver stalls, the following result
// waits in the datapath until the output register is free.
// ----------------------------------------------------------------------------
module register_vm_integer_execute_top #(
  parameter int BANK_DEPTH  = 256,
  parameter int VALUE_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation, dest_bank, dest_index, left_bank, left_field, right_bank,
  // right_field, host_value, zero pad
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_value, wrote, next_pointer, branch_taken, returned, error_code,
  // zero pad
  output logic [103:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  rvie_pkg::cmd_t cmd;
  rvie_pkg::sts_t sts;

  logic [7:0]                       argc_r;
  logic [rvie_pkg::PTR_W-1:0]       sp_r;
  logic                             cfg_we;
  logic                             ip_load_nxt;
  logic                             ip_load_r;
  logic [rvie_pkg::FULL_W-1:0]      result_value;
  logic                             wrote, branch_taken, returned;
  logic [rvie_pkg::PTR_W-1:0]       next_pointer;
  logic [1:0]                       error_code;

  assign cfg_pready  = 1'b1;
  assign cfg_we      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ip_load_nxt = cfg_we && (cfg_paddr[2] == rvie_pkg::CFG_START);
  assign cfg_prdata  = (cfg_paddr[2] == rvie_pkg::CFG_START) ? sp_r : {24'd0, argc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      argc_r    <= '0;
      sp_r      <= '0;
      ip_load_r <= 1'b0;
    end else begin
      ip_load_r <= ip_load_nxt;
      if (cfg_we) begin
        if (cfg_paddr[2] == rvie_pkg::CFG_START) begin
          sp_r <= cfg_pwdata;
        end else begin
          argc_r <= cfg_pwdata[7:0];
        end
      end
    end
  end

  rvie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rvie_dp #(
    .BANK_DEPTH  (BANK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (in_tdata[4:0]),
    .dest_bank      (in_tdata[6:5]),
    .dest_index     (in_tdata[22:7]),
    .left_bank      (in_tdata[24:23]),
    .left_field     (in_tdata[40:25]),
    .right_bank     (in_tdata[42:41]),
    .right_field    (in_tdata[58:43]),
    .host_value     (in_tdata[122:59]),
    .argument_count (argc_r),
    .start_pointer  (sp_r),
    .ip_load        (ip_load_r),
    .result_value   (result_value),
    .wrote          (wrote),
    .next_pointer   (next_pointer),
    .branch_taken   (branch_taken),
    .returned       (returned),
    .error_code     (error_code)
  );

  assign out_tdata = {3'd0, error_code, returned, branch_taken, next_pointer, wrote,
                      result_value};

endmodule

>>> verif/register_vm_integer_execute_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_vm_integer_execute_top_tb
// Drives instructions into the execute unit and checks every result against
// a behavioral predictor that keeps its own operand store, instruction
// pointer and register copies. A short table of directed requests covers
// the extreme cases; random programs follow under random backpressure.
// ----------------------------------------------------------------------------
module register_vm_integer_execute_top_tb;

  localparam int DEPTH = 256;
  localparam int N_RANDOM = 500;

  typedef struct packed {
    logic [1:0]  err;
    logic        ret;
    logic        br;
    logic [31:0] nxt;
    logic        wr;
    logic [63:0] val;
  } result_t;

  typedef struct {
    rvie_pkg::op_t op;
    logic [1:0]  db;
    logic [15:0] di;
    logic [1:0]  lb;
    logic [15:0] lf;
    logic [1:0]  rb;
    logic [15:0] rf;
    logic [63:0] hv;
  } instr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  logic [63:0] store_copy [4*DEPTH];
  logic [31:0] ip_copy;
  logic [7:0]  argc_copy;
  logic [31:0] start_copy;
  result_t     pending_results [$];
  int          fail_count = 0;
  bit          hold_off = 1'b0;
  bit          quiet_rx = 1'b0;

  register_vm_integer_execute_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] sdivide(logic [63:0] a, logic [63:0] b, bit rem);
    logic [63:0] ma, mb, q, r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (rem) return a[63] ? -r : r;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic result_t execute_instr(instr_t x);
    result_t r;
    bit ud, ul, ur, wr;
    logic [63:0] a, b, d, v;
    logic [31:0] imm;
    logic [5:0] sh;
    logic [4:0] op;
    op = x.op;
    r = '0;
    a = '0; b = '0; d = '0; v = '0; wr = 0;
    imm = {x.lf, x.rf};
    ud = (op >= 1 && op <= 21) || op == rvie_pkg::OP_JCOND || op == rvie_pkg::OP_HOST ||
         op == rvie_pkg::OP_RET;
    ul = (op >= 1 && op <= 18) || op == rvie_pkg::OP_COPY;
    ur = (op >= 1 && op <= 14) || op == rvie_pkg::OP_LSH || op == rvie_pkg::OP_RSH;
    r.nxt = ip_copy + 1;
    if ((ud && x.di >= DEPTH) || (ul && x.lf >= DEPTH) || (ur && x.rf >= DEPTH))
      r.err = rvie_pkg::ERR_INDEX;
    if (r.err == rvie_pkg::ERR_NONE) begin
      if (ud) d = store_copy[x.db*DEPTH + x.di];
      if (ul) a = store_copy[x.lb*DEPTH + x.lf];
      if (ur) b = store_copy[x.rb*DEPTH + x.rf];
      if ((op == rvie_pkg::OP_DIV || op == rvie_pkg::OP_MOD) && b == 0)
        r.err = rvie_pkg::ERR_ZERO_DIV;
    end
    if (r.err == rvie_pkg::ERR_NONE) begin
      wr = 1;
      sh = b[5:0];
      case (op)
        rvie_pkg::OP_ADD: v = a + b;
        rvie_pkg::OP_SUB: v = a - b;
        rvie_pkg::OP_MUL: v = a * b;
        rvie_pkg::OP_DIV: v = sdivide(a, b, 0);
        rvie_pkg::OP_MOD: v = sdivide(a, b, 1);
        rvie_pkg::OP_EQ: v = 64'(a == b);
        rvie_pkg::OP_GT: v = 64'($signed(a) > $signed(b));
        rvie_pkg::OP_LT: v = 64'($signed(a) < $signed(b));
        rvie_pkg::OP_NE: v = 64'(a != b);
        rvie_pkg::OP_GE: v = 64'($signed(a) >= $signed(b));
        rvie_pkg::OP_LE: v = 64'($signed(a) <= $signed(b));
        rvie_pkg::OP_AND: v = a & b;
        rvie_pkg::OP_OR: v = a | b;
        rvie_pkg::OP_XOR: v = a ^ b;
        rvie_pkg::OP_NOT: v = ~a;
        rvie_pkg::OP_NEG: v = -a;
        rvie_pkg::OP_LSH: v = a << sh;
        rvie_pkg::OP_RSH: v = $signed(a) >>> sh;
        rvie_pkg::OP_LDI: v = {32'b0, imm};
        rvie_pkg::OP_COPY: v = a;
        rvie_pkg::OP_ARGC: v = {56'b0, argc_copy};
        rvie_pkg::OP_HOST: begin
          v = x.hv;
          r.nxt = ip_copy;
        end
        default: wr = 0;
      endcase
      if (wr) store_copy[x.db*DEPTH + x.di] = v;
      if (op == rvie_pkg::OP_JMP || (op == rvie_pkg::OP_JCOND && d != 0)) begin
        r.nxt = ip_copy + 1 + imm;
        r.br = 1;
      end
    end
    r.wr = wr;
    r.val = wr ? v : '0;
    if (op == rvie_pkg::OP_RET) begin
      r.ret = 1;
      r.val = (r.err == rvie_pkg::ERR_NONE) ? d : '0;
      r.nxt = start_copy;
    end
    ip_copy = r.nxt;
    return r;
  endfunction

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == 3'd0) argc_copy = data[7:0];
    else begin
      start_copy = data;
      ip_copy = data;
    end
    @(posedge clk);
  endtask

  // Sends one request; a known result, if given, must agree with the predictor.
  task automatic send_instr(instr_t x, bit known, result_t known_res);
    result_t r;
    while (!hold_off && $urandom_range(99) < 25 && !quiet_rx) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {5'd0, x.hv, x.rf, x.rb, x.lf, x.lb, x.di, x.db, 5'(x.op)};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = execute_instr(x);
    if (known && r != known_res) begin
      $display("%0t table mismatch: expected %h, actual %h", $time, known_res, r);
      fail_count++;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[100:0];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.val !== want.val || got.wr !== want.wr || got.nxt !== want.nxt ||
            got.br !== want.br || got.ret !== want.ret || got.err !== want.err) begin
          $display("%0t result mismatch: expected %h, actual %h", $time, want, got);
          fail_count++;
        end
      end
    end
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 25);
  end

  function automatic instr_t mk(rvie_pkg::op_t op, int db, int di, int lb, int lf,
                                int rb, int rf, logic [63:0] hv);
    instr_t x;
    x.op = op; x.db = 2'(db); x.di = 16'(di); x.lb = 2'(lb); x.lf = 16'(lf);
    x.rb = 2'(rb); x.rf = 16'(rf); x.hv = hv;
    return x;
  endfunction

  function automatic instr_t random_instr();
    instr_t x;
    int sel;
    sel = $urandom_range(99);
    x.op = rvie_pkg::op_t'($urandom_range(rvie_pkg::OP_RET));
    if (sel < 3) x.op = rvie_pkg::op_t'($urandom_range(31, 26));
    x.db = 2'($urandom_range(3));
    x.lb = 2'($urandom_range(3));
    x.rb = 2'($urandom_range(3));
    x.di = 16'($urandom_range(7));
    x.lf = 16'($urandom_range(7));
    x.rf = 16'($urandom_range(7));
    if (sel >= 90) begin
      x.di = 16'($urandom);
      x.lf = 16'($urandom);
      x.rf = 16'($urandom);
    end
    if (x.op == rvie_pkg::OP_LDI || x.op == rvie_pkg::OP_JMP || x.op == rvie_pkg::OP_JCOND)
    begin
      x.lf = 16'($urandom);
      x.rf = 16'($urandom);
      if (x.op == rvie_pkg::OP_JCOND && sel < 80) x.di = 16'($urandom_range(7));
    end
    case ($urandom_range(3))
      0: x.hv = {$urandom, $urandom};
      1: x.hv = 64'(int'($urandom_range(3)) - 2);
      2: x.hv = {1'b1, 63'b0};
      default: x.hv = 64'($urandom_range(70));
    endcase
    return x;
  endfunction

  instr_t  dir_instr [$];
  bit      dir_known [$];
  result_t dir_res   [$];

  task automatic add_row(instr_t x, bit known, result_t r);
    dir_instr.push_back(x);
    dir_known.push_back(known);
    dir_res.push_back(r);
  endtask

  initial begin
    result_t k;
    int cnt;
    for (int i = 0; i < 4*DEPTH; i++) store_copy[i] = '0;
    ip_copy = '0;
    argc_copy = '0;
    start_copy = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    k = '0; k.nxt = 32'd1;
    add_row(mk(rvie_pkg::OP_NOP, 0, 0, 0, 0, 0, 0, '0), 1, k);
    k = '0; k.nxt = 32'd1;
    add_row(mk(rvie_pkg::OP_HOST, 1, 0, 0, 0, 0, 0, {1'b1, 63'b0}), 1, k);
    k.val = {1'b1, 63'b0}; k.wr = 1;
    dir_res[1] = k;
    add_row(mk(rvie_pkg::OP_HOST, 1, 1, 0, 0, 0, 0, '1), 0, k);
    add_row(mk(rvie_pkg::OP_HOST, 3, 255, 0, 0, 0, 0, 64'h7fff_ffff_ffff_ffff), 0, k);
    add_row(mk(rvie_pkg::OP_DIV, 2, 0, 1, 0, 1, 1, '0), 0, k);
    add_row(mk(rvie_pkg::OP_MOD, 2, 1, 1, 0, 1, 1, '0), 0, k);
    k = '0; k.err = rvie_pkg::ERR_ZERO_DIV; k.nxt = 32'd4;
    add_row(mk(rvie_pkg::OP_DIV, 2, 2, 1, 0, 0, 5, '0), 1, k);
    k.nxt = 32'd5;
    add_row(mk(rvie_pkg::OP_MOD, 2, 2, 1, 0, 0, 5, '0), 1, k);
    k = '0; k.err = rvie_pkg::ERR_INDEX; k.nxt = 32'd6;
    add_row(mk(rvie_pkg::OP_ADD, 2, 16'hffff, 1, 0, 1, 0, '0), 1, k);
    k.nxt = 32'd7;
    add_row(mk(rvie_pkg::OP_DIV, 2, 0, 1, 0, 0, 256, '0), 1, k);
    for (int o = rvie_pkg::OP_ADD; o <= rvie_pkg::OP_ARGC; o++)
      add_row(mk(rvie_pkg::op_t'(o), 2, o, 1, 0, 3, 255, '0), 0, k);
    add_row(mk(rvie_pkg::OP_LSH, 2, 3, 3, 255, 1, 1, '0), 0, k);
    add_row(mk(rvie_pkg::OP_LDI, 2, 4, 0, 16'hffff, 0, 16'hffff, '0), 0, k);
    add_row(mk(rvie_pkg::OP_JMP, 0, 0, 0, 16'hffff, 0, 16'hfffe, '0), 0, k);
    add_row(mk(rvie_pkg::OP_JCOND, 1, 0, 0, 16'h8000, 0, 0, '0), 0, k);
    add_row(mk(rvie_pkg::OP_JCOND, 0, 0, 0, 0, 0, 9, '0), 0, k);
    add_row(mk(rvie_pkg::OP_RET, 3, 255, 0, 0, 0, 0, '0), 0, k);
    add_row(mk(rvie_pkg::OP_RET, 3, 300, 0, 0, 0, 0, '0), 0, k);
    add_row(mk(rvie_pkg::op_t'(5'd31), 0, 0, 0, 0, 0, 0, '0), 0, k);

    while (!in_tready) @(posedge clk);
    for (int i = 0; i < dir_instr.size(); i++)
      send_instr(dir_instr[i], dir_known[i], dir_res[i]);
    drain();

    cfg_write(3'd0, 32'd255);
    cfg_write(3'd4, 32'hffff_fff0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 150) begin
        drain();
        cfg_write(3'd0, 32'd0);
        cfg_write(3'd4, 32'h0);
      end
      if (i == 300) begin
        drain();
        cfg_write(3'd0, $urandom_range(255));
        cfg_write(3'd4, $urandom);
      end
      if (i == 200) begin
        fork
          begin
            hold_off = 1'b1;
            cnt = 0;
            while (cnt < 300) begin
              @(posedge clk);
              cnt++;
            end
            hold_off = 1'b0;
          end
        join_none
      end
      quiet_rx = (i >= 400 && i < 450);
      send_instr(random_instr(), 0, k);
    end
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
